// ----- hdl/rorb_pkg.sv -----
package rorb_pkg;

   localparam int WINDOW       = 32;
   localparam int PAYLOAD_BITS = 32;

   localparam int SEQ_W   = 32;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   // stored width: input word kept to its low PAYLOAD_BITS bits
   localparam int STORE_W = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

   localparam logic [SEQ_W-1:0] SEQ_RESET     = SEQ_W'(1);
   localparam logic [SEQ_W-1:0] SEQ_LAST      = {SEQ_W{1'b1}};
   localparam logic [IDX_W-1:0] IDX_RESET     = IDX_W'(1 % WINDOW);
   localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(WINDOW - 1);

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [STORE_W-1:0] store_data_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq_num;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  out_seq;
      logic [DATA_W-1:0] out_payload;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic    wr_en;
      idx_type wr_idx;
      logic    rd_en;
      idx_type rd_idx;
      idx_type nx_idx;
   } slot_cmd_type;

   typedef struct packed {
      logic cur_valid;
      logic next_valid;
   } slot_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // (a + b) mod WINDOW for a, b < WINDOW
   function automatic idx_type idx_add(input idx_type a, input idx_type b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W+1)'(WINDOW)) begin
         sum = sum - (IDX_W+1)'(WINDOW);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- hdl/rorb_slot_store.sv -----
module rorb_slot_store (
   input  logic                    clock,
   input  logic                    reset,
   input  rorb_pkg::slot_cmd_type  cmd,
   input  rorb_pkg::store_data_type wr_data,
   output rorb_pkg::slot_stat_type stat,
   output rorb_pkg::store_data_type rd_data
);

   logic [rorb_pkg::WINDOW-1:0] valid_ff;
   logic [rorb_pkg::WINDOW-1:0] valid_in;
   rorb_pkg::store_data_type    mem [rorb_pkg::WINDOW];
   rorb_pkg::store_data_type    rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_idx] = 1'b1;
      end
      if (cmd.rd_en) begin
         valid_in[cmd.rd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx];
      end
   end

   assign stat.cur_valid  = valid_ff[cmd.rd_idx];
   assign stat.next_valid = valid_ff[cmd.nx_idx];
   assign rd_data         = rd_data_ff;

endmodule

// ----- hdl/rorb_window_unit.sv -----
module rorb_window_unit (
   input  logic [rorb_pkg::SEQ_W-1:0] seq_num,
   input  logic [rorb_pkg::SEQ_W-1:0] expected,
   input  rorb_pkg::idx_type          exp_idx,
   output logic                       in_window,
   output rorb_pkg::idx_type          slot_idx
);

   logic [rorb_pkg::SEQ_W:0] diff;

   // borrow out of the subtract means already released
   assign diff = {1'b0, seq_num} - {1'b0, expected};

   assign in_window = (seq_num != '0) && (expected != '0) && !diff[rorb_pkg::SEQ_W]
                      && (diff[rorb_pkg::SEQ_W-1:0] < rorb_pkg::SEQ_W'(rorb_pkg::WINDOW));

   // seq mod WINDOW, derived from the tracked index of expected
   assign slot_idx = rorb_pkg::idx_add(exp_idx, diff[rorb_pkg::IDX_W-1:0]);

endmodule

// ----- hdl/in_order_release_reorder_buffer.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | rorb_pkg::req_type  (seq_num, payload)
// rsp     | out       | rsp_valid/rsp_ready  | rorb_pkg::rsp_type  (out_seq, out_payload, run_last)
//
// A dropped item is taken without leaving idle; a stored item that releases nothing enters
// the drain state and returns to idle. An item that releases a run drains its N results,
// one slot read a cycle through the single payload memory port while rsp does not stall.
// req_ready is low while a run drains; the last result may wait in the output
// register while the next item is taken. Reset is synchronous, no clearing pass.
module in_order_release_reorder_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rorb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rorb_pkg::rsp_type rsp_data
);

   rorb_pkg::state_type        state_ff, state_in;
   logic [rorb_pkg::SEQ_W-1:0] expected_ff, expected_in;
   rorb_pkg::idx_type          exp_idx_ff, exp_idx_in;
   rorb_pkg::idx_type          count_ff, count_in;
   logic [rorb_pkg::SEQ_W-1:0] out_seq_ff, out_seq_in;
   logic                       run_last_ff, run_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   rorb_pkg::slot_cmd_type     cmd;
   rorb_pkg::slot_stat_type    stat;
   rorb_pkg::store_data_type   rd_data;
   rorb_pkg::idx_type          wr_idx;
   rorb_pkg::idx_type          nx_idx;
   logic                       in_window;
   logic                       accept;
   logic                       out_free;
   logic                       load;
   logic                       last;

   rorb_window_unit u_window (
      .seq_num   (req_data.seq_num),
      .expected  (expected_ff),
      .exp_idx   (exp_idx_ff),
      .in_window (in_window),
      .slot_idx  (wr_idx)
   );

   assign req_ready = (state_ff == rorb_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign nx_idx    = rorb_pkg::idx_add(exp_idx_ff, rorb_pkg::IDX_W'(1));
   assign load      = (state_ff == rorb_pkg::ST_DRAIN) && stat.cur_valid && out_free;
   // run ends at a gap, at WINDOW results, or when sequence space runs out
   assign last      = !stat.next_valid || (count_ff == rorb_pkg::IDX_LAST)
                      || (expected_ff == rorb_pkg::SEQ_LAST);

   assign cmd.wr_en  = accept && in_window;
   assign cmd.wr_idx = wr_idx;
   assign cmd.rd_en  = load;
   assign cmd.rd_idx = exp_idx_ff;
   assign cmd.nx_idx = nx_idx;

   rorb_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_data (req_data.payload[rorb_pkg::STORE_W-1:0]),
      .stat    (stat),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      expected_in  = expected_ff;
      exp_idx_in   = exp_idx_ff;
      count_in     = count_ff;
      out_seq_in   = out_seq_ff;
      run_last_in  = run_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         rorb_pkg::ST_IDLE: begin
            if (accept && in_window) begin
               state_in = rorb_pkg::ST_DRAIN;
               count_in = '0;
            end
         end
         rorb_pkg::ST_DRAIN: begin
            if (!stat.cur_valid) begin
               state_in = rorb_pkg::ST_IDLE;
            end else if (out_free) begin
               out_seq_in   = expected_ff;
               run_last_in  = last;
               rsp_valid_in = 1'b1;
               expected_in  = expected_ff + rorb_pkg::SEQ_W'(1);
               exp_idx_in   = nx_idx;
               count_in     = count_ff + rorb_pkg::IDX_W'(1);
               if (last) begin
                  state_in = rorb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rorb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rorb_pkg::ST_IDLE;
         expected_ff  <= rorb_pkg::SEQ_RESET;
         exp_idx_ff   <= rorb_pkg::IDX_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         exp_idx_ff   <= exp_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_seq_ff  <= out_seq_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.out_seq     = out_seq_ff;
   assign rsp_data.out_payload = rorb_pkg::DATA_W'(rd_data);
   assign rsp_data.run_last    = run_last_ff;

endmodule

// ----- test/in_order_release_reorder_buffer_test.sv -----
module in_order_release_reorder_buffer_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rorb_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rorb_pkg::rsp_type rsp_data;

   in_order_release_reorder_buffer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [rorb_pkg::SEQ_W-1:0] next_seq;
   logic                       held [rorb_pkg::WINDOW];
   rorb_pkg::store_data_type   held_data [rorb_pkg::WINDOW];
   rorb_pkg::rsp_type          pending_releases [$];

   bit   no_idle = 1'b0;
   int   errors = 0;
   int   cycles = 0;
   int   items_sent = 0;
   int   items_held = 0;
   int   releases_checked = 0;
   int   longest_run = 0;
   int   stall_left = 0;

   function automatic int slot_of(input logic [rorb_pkg::SEQ_W-1:0] seq);
      return int'(seq % rorb_pkg::SEQ_W'(rorb_pkg::WINDOW));
   endfunction

   // apply one accepted item, queue the messages it releases
   function automatic void predict_release(input rorb_pkg::req_type item);
      logic [rorb_pkg::SEQ_W-1:0] gap;
      rorb_pkg::rsp_type          msg;
      int                         count;
      count = 0;
      if (item.seq_num == '0 || next_seq == '0 || item.seq_num < next_seq) begin
         return;
      end
      gap = item.seq_num - next_seq;
      if (gap >= rorb_pkg::SEQ_W'(rorb_pkg::WINDOW)) begin
         return;
      end
      items_held++;
      held[slot_of(item.seq_num)] = 1'b1;
      held_data[slot_of(item.seq_num)] = item.payload[rorb_pkg::STORE_W-1:0];
      while (next_seq != '0 && count < rorb_pkg::WINDOW && held[slot_of(next_seq)]) begin
         msg.out_seq = next_seq;
         msg.out_payload = rorb_pkg::DATA_W'(held_data[slot_of(next_seq)]);
         held[slot_of(next_seq)] = 1'b0;
         next_seq = next_seq + rorb_pkg::SEQ_W'(1);
         count++;
         // sequence space exhausted ends a run too
         msg.run_last = !(next_seq != '0 && count < rorb_pkg::WINDOW
                          && held[slot_of(next_seq)]);
         pending_releases.insert(pending_releases.size(), msg);
      end
      if (count > longest_run) begin
         longest_run = count;
      end
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_releases.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) begin
            rsp_ready <= 1'b1;
         end
      end else if (!reset && !no_idle && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(1, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rorb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_releases.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result: seq %h payload %h last %b",
                        rsp_data.out_seq, rsp_data.out_payload, rsp_data.run_last);
            end
         end else begin
            want = pending_releases.pop_front();
            releases_checked++;
            if (rsp_data.out_seq !== want.out_seq ||
                rsp_data.out_payload !== want.out_payload ||
                rsp_data.run_last !== want.run_last) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: expected seq %h payload %h last %b,",
                           want.out_seq, want.out_payload, want.run_last);
                  $display("          got seq %h payload %h last %b",
                           rsp_data.out_seq, rsp_data.out_payload, rsp_data.run_last);
               end
            end
         end
      end
   end

   // valid stays high after return; callers that wait lower it first
   task automatic send_item(input logic [rorb_pkg::SEQ_W-1:0] seq,
                            input logic [rorb_pkg::DATA_W-1:0] data);
      rorb_pkg::req_type item;
      item.seq_num = seq;
      item.payload = data;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      predict_release(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_releases.size() != 0) @(posedge clock);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_item('0, $urandom);
         1: send_item(next_seq > 1 ? next_seq - rorb_pkg::SEQ_W'($urandom_range(1, 40)) : '0,
                      $urandom);
         2: send_item(next_seq + rorb_pkg::SEQ_W'(rorb_pkg::WINDOW)
                      + rorb_pkg::SEQ_W'($urandom_range(0, 100)), $urandom);
         default: send_item($urandom, $urandom);
      endcase
   endtask

   // consecutive numbers from the release point, shuffled, with some holes,
   // repeats and noise mixed in
   task automatic send_block(input int len);
      logic [rorb_pkg::SEQ_W-1:0] order [$];
      logic [rorb_pkg::SEQ_W-1:0] tmp;
      logic [rorb_pkg::SEQ_W-1:0] base;
      int                         j;
      int                         skip;
      base = next_seq;
      skip = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = skip; i < len; i++) begin
         order.insert(order.size(), base + rorb_pkg::SEQ_W'(i));
      end
      for (int i = order.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) begin
         if ($urandom_range(0, 6) == 0) begin
            send_noise();
         end
         send_item(order[i], $urandom);
         if ($urandom_range(0, 9) == 0) begin
            send_item(order[i], $urandom);
         end
      end
   endtask

   task automatic test_drop_cases();
      send_item('0, '1);
      send_item('1, '0);
      send_item(32'h8000_0000, 32'h5A5A_A5A5);
      wait_drained();
   endtask

   task automatic test_single_release();
      send_item(rorb_pkg::SEQ_RESET, '0);
      send_item(rorb_pkg::SEQ_RESET, '1);
      wait_drained();
   endtask

   task automatic test_window_edges();
      logic [rorb_pkg::SEQ_W-1:0] base;
      base = next_seq;
      send_item(base + rorb_pkg::SEQ_W'(rorb_pkg::WINDOW - 1), '1);
      send_item(base + rorb_pkg::SEQ_W'(rorb_pkg::WINDOW), 32'h1234_5678);
      send_item(base + rorb_pkg::SEQ_W'(1), 32'hAAAA_5555);
      send_item(base + rorb_pkg::SEQ_W'(1), 32'h5555_AAAA);
      send_item(base, 32'hFFFF_0000);
      wait_drained();
   endtask

   // fill the whole window backwards, then the release point frees all of it
   task automatic test_full_window();
      logic [rorb_pkg::SEQ_W-1:0] base;
      base = next_seq;
      for (int i = rorb_pkg::WINDOW - 1; i >= 1; i--) begin
         send_item(base + rorb_pkg::SEQ_W'(i), $urandom);
      end
      send_item(base, $urandom);
      wait_drained();
   endtask

   task automatic test_hold_until_drained();
      for (int k = 0; k < 4; k++) begin
         send_block($urandom_range(1, 8));
         wait_drained();
      end
   endtask

   task automatic test_random_traffic(input int target);
      int goal;
      goal = items_held + target;
      while (items_held < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else if ($urandom_range(0, 5) == 0) begin
            send_block($urandom_range(20, rorb_pkg::WINDOW));
         end else begin
            send_block($urandom_range(1, 10));
         end
      end
      wait_drained();
   endtask

   task automatic test_back_to_back(input int target);
      int goal;
      no_idle = 1'b1;
      goal = items_held + target;
      while (items_held < goal) begin
         send_block($urandom_range(1, rorb_pkg::WINDOW));
      end
      wait_drained();
   endtask

   initial begin
      next_seq = rorb_pkg::SEQ_RESET;
      foreach (held[i]) begin
         held[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_drop_cases();
      test_single_release();
      test_window_edges();
      test_full_window();
      test_hold_until_drained();
      test_random_traffic(150);
      test_back_to_back(40);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_releases.size() != 0) begin
         errors++;
         $display("%0d expected results never arrived", pending_releases.size());
      end
      $display("%0d items sent, %0d held in the window, %0d releases checked",
               items_sent, items_held, releases_checked);
      $display("longest run %0d, drops, repeats and stalls on both sides mixed in",
               longest_run);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
